>>> rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and a helper function of the bit store engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int BIT_CAPACITY = 4096;
  localparam int WORD_BITS    = 32;
  localparam int STORE_WORDS  = BIT_CAPACITY / WORD_BITS;
  localparam int WADDR_W      = $clog2(STORE_WORDS);
  localparam int WSEL_W       = $clog2(WORD_BITS);
  localparam int BIDX_W       = $clog2(BIT_CAPACITY);
  localparam int LEN_W        = BIDX_W + 1;
  localparam int POP_W        = WSEL_W + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [WSEL_W-1:0]    wsel_t;
  typedef logic [BIDX_W-1:0]    bidx_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [POP_W-1:0]     pop_t;

  localparam word_t WORD_ONES = '1;
  localparam len_t  LEN_MAX   = len_t'(BIT_CAPACITY);

  typedef enum logic [2:0] {
    FN_WRITE  = 3'd0,
    FN_TOGGLE = 3'd1,
    FN_TEST   = 3'd2,
    FN_FILL   = 3'd3,
    FN_COUNT  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_WALK,
    ST_CNT_FIN
  } state_t;

  typedef struct packed {
    logic   rd_en;
    waddr_t rd_addr;
    logic   wr_en;
    waddr_t wr_addr;
    word_t  wr_data;
  } mem_req_t;

  function automatic pop_t pop32(input word_t w);
    word_t v;
    v = w - ((w >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0F0F_0F0F;
    v = v + (v >> 8);
    v = v + (v >> 16);
    return pop_t'(v[7:0]);
  endfunction

endpackage

>>> rtl/core/bse_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_mem
// Word store with one read and one write port, registered read data and a
// written flag per word so that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module bse_mem
  import bse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output word_t    rd_data
);

  word_t                  mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_r;
  word_t                  rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/bse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ctrl
// Request sequencer: single bit read-modify-write, streamed word walk for
// range fill and population count, result registers.
// ----------------------------------------------------------------------------
module bse_ctrl
  import bse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_func,
  input  bidx_t      req_index,
  input  len_t       req_end,
  input  logic       req_value,
  input  logic       req_ones,
  input  len_t       act_len,
  output mem_req_t   mem_req,
  input  word_t      rd_data,
  output logic       res_valid,
  output logic       res_old,
  output len_t       res_total,
  output logic       res_error
);

  state_t state_r, state_nxt;
  logic   fill_r, fill_nxt;
  logic   wr_bit_r, wr_bit_nxt;
  logic   test_r, test_nxt;
  logic   val_r, val_nxt;
  logic   ones_r, ones_nxt;
  wsel_t  sel_r, sel_nxt;
  len_t   len_r, len_nxt;
  waddr_t ptr_r, ptr_nxt;
  waddr_t first_r, first_nxt;
  waddr_t last_r, last_nxt;
  wsel_t  lo_r, lo_nxt;
  wsel_t  hib_r, hib_nxt;
  logic   iss_done_r, iss_done_nxt;
  logic   pend_r, pend_nxt;
  waddr_t paddr_r, paddr_nxt;
  len_t   acc_r, acc_nxt;
  logic   vld_r, vld_nxt;
  logic   old_r, old_nxt;
  len_t   total_r, total_nxt;
  logic   err_r, err_nxt;

  len_t   elast;
  word_t  mask;
  word_t  new_word;
  logic   old_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    wr_bit_r   <= wr_bit_nxt;
    test_r     <= test_nxt;
    val_r      <= val_nxt;
    ones_r     <= ones_nxt;
    sel_r      <= sel_nxt;
    len_r      <= len_nxt;
    ptr_r      <= ptr_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hib_r      <= hib_nxt;
    iss_done_r <= iss_done_nxt;
    pend_r     <= pend_nxt;
    paddr_r    <= paddr_nxt;
    acc_r      <= acc_nxt;
    old_r      <= old_nxt;
    total_r    <= total_nxt;
    err_r      <= err_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    wr_bit_nxt   = wr_bit_r;
    test_nxt     = test_r;
    val_nxt      = val_r;
    ones_nxt     = ones_r;
    sel_nxt      = sel_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    lo_nxt       = lo_r;
    hib_nxt      = hib_r;
    iss_done_nxt = iss_done_r;
    pend_nxt     = pend_r;
    paddr_nxt    = paddr_r;
    acc_nxt      = acc_r;
    vld_nxt      = 1'b0;
    old_nxt      = 1'b0;
    total_nxt    = '0;
    err_nxt      = 1'b0;
    mem_req      = '0;
    elast        = '0;
    mask         = WORD_ONES;
    new_word     = rd_data;
    old_bit      = rd_data[sel_r];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          wr_bit_nxt = (req_func == FN_WRITE);
          test_nxt   = (req_func == FN_TEST);
          fill_nxt   = (req_func == FN_FILL);
          val_nxt    = req_value;
          ones_nxt   = req_ones;
          sel_nxt    = req_index[WSEL_W-1:0];
          len_nxt    = act_len;
          pend_nxt   = 1'b0;
          iss_done_nxt = 1'b0;
          acc_nxt    = '0;
          if (req_func == FN_WRITE || req_func == FN_TOGGLE || req_func == FN_TEST) begin
            if ({1'b0, req_index} >= act_len) begin
              vld_nxt = 1'b1;
              err_nxt = 1'b1;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = req_index[BIDX_W-1:WSEL_W];
              state_nxt       = ST_BIT;
            end
          end else if (req_func == FN_FILL) begin
            if ({1'b0, req_index} > req_end || req_end > act_len) begin
              vld_nxt = 1'b1;
              err_nxt = 1'b1;
            end else if ({1'b0, req_index} == req_end) begin
              vld_nxt = 1'b1;
            end else begin
              elast     = req_end - len_t'(1);
              first_nxt = req_index[BIDX_W-1:WSEL_W];
              ptr_nxt   = req_index[BIDX_W-1:WSEL_W];
              lo_nxt    = req_index[WSEL_W-1:0];
              last_nxt  = elast[BIDX_W-1:WSEL_W];
              hib_nxt   = elast[WSEL_W-1:0];
              state_nxt = ST_WALK;
            end
          end else if (req_func == FN_COUNT) begin
            if (act_len == '0) begin
              vld_nxt = 1'b1;
            end else begin
              elast     = act_len - len_t'(1);
              first_nxt = '0;
              ptr_nxt   = '0;
              lo_nxt    = '0;
              last_nxt  = elast[BIDX_W-1:WSEL_W];
              hib_nxt   = elast[WSEL_W-1:0];
              state_nxt = ST_WALK;
            end
          end else begin
            vld_nxt = 1'b1;
            err_nxt = 1'b1;
          end
        end
      end

      ST_BIT: begin
        new_word[sel_r] = wr_bit_r ? val_r : ~old_bit;
        mem_req.wr_en   = !test_r;
        mem_req.wr_addr = paddr_r;
        mem_req.wr_data = new_word;
        old_nxt         = wr_bit_r ? 1'b0 : old_bit;
        vld_nxt         = 1'b1;
        state_nxt       = ST_IDLE;
      end

      ST_WALK: begin
        if (!iss_done_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r;
          ptr_nxt         = ptr_r + waddr_t'(1);
          iss_done_nxt    = (ptr_r == last_r);
        end
        pend_nxt  = !iss_done_r;
        paddr_nxt = ptr_r;
        if (pend_r) begin
          if (paddr_r == first_r) begin
            mask = mask & (WORD_ONES << lo_r);
          end
          if (paddr_r == last_r) begin
            mask = mask & (WORD_ONES >> (~hib_r));
          end
          if (fill_r) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = paddr_r;
            mem_req.wr_data = val_r ? (rd_data | mask) : (rd_data & ~mask);
          end else begin
            acc_nxt = acc_r + len_t'(pop32(rd_data & mask));
          end
          if (paddr_r == last_r) begin
            if (fill_r) begin
              vld_nxt   = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_CNT_FIN;
            end
          end
        end
      end

      ST_CNT_FIN: begin
        total_nxt = ones_r ? acc_r : len_r - acc_r;
        vld_nxt   = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // single bit access keeps its word address for the write back
    if (state_r == ST_IDLE && start) begin
      paddr_nxt = req_index[BIDX_W-1:WSEL_W];
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = vld_r;
  assign res_old   = old_r;
  assign res_total = total_r;
  assign res_error = err_r;

endmodule

>>> rtl/core/bitmap_store_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_store_engine_core
// 4096-bit store in 128 words of 32 bits with bit write, toggle, test,
// range fill and population count over the active length.
// ----------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; in_func selects
//   write bit, toggle bit, test bit, fill range or count.
//   each transaction gives one result: out_valid is high for one cycle with
//   out_old_bit, out_bit_total and out_error. the receiver cannot stall.
//   cfg_active_bits is written with cfg_valid (cfg_ready is always high).
//   the user writes it only while no request is in flight; the block does
//   not enforce this. values above 4096 act as 4096.
// sequence
//   bad index, bad range, empty fill, count of zero length: result in the
//   cycle after the transaction is taken. write, toggle, test: one
//   read-modify-write of a word (test does not write back) through ST_BIT.
//   fill, count: one word is read per cycle through the single read port
//   of the word store; count ends in ST_CNT_FIN.
// reset
//   rst_n low clears the store to zeros (per-word written flags) and sets
//   the active length to 4096. no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_store_engine_core
  import bse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  bidx_t       in_bit_index,
  input  len_t        in_range_end,
  input  logic        in_bit_value,
  input  logic        in_count_ones,
  output logic        out_valid,
  output logic        out_old_bit,
  output len_t        out_bit_total,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  len_t        cfg_active_bits
);

  len_t     active_r;
  len_t     act_len;
  mem_req_t mem_req;
  word_t    rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= LEN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_active_bits;
    end
  end

  assign act_len = (active_r > LEN_MAX) ? LEN_MAX : active_r;

  bse_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_func  (in_func),
    .req_index (in_bit_index),
    .req_end   (in_range_end),
    .req_value (in_bit_value),
    .req_ones  (in_count_ones),
    .act_len   (act_len),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (out_valid),
    .res_old   (out_old_bit),
    .res_total (out_bit_total),
    .res_error (out_error)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither in progress nor answered");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_count_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bit_total != '0) |-> !out_error)
    else $error("count result flagged as error");

  a_old_bit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_old_bit |-> !out_error && (out_bit_total == '0))
    else $error("old bit returned with error or count");

endmodule
